FILE: rtl/aar_pkg.sv
// shared constants, tables and types for the axis-angle rotation matrix block
package aar_pkg;

    localparam int ANGLE_W      = 16;
    localparam int CFG_W        = 16;
    localparam int ENTRY_W      = 18;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam int REG_MIN_AXIS_LENGTH = 0;
    localparam int MIN_AXIS_RESET      = 7;

    localparam int FULL_TURN    = 23040;
    localparam int HALF_TURN    = 11520;
    localparam int QUARTER_TURN = 5760;
    localparam int RAD_PER_UNIT = 292818;
    localparam int CORDIC_GAIN  = 32'h26DD3B6A;
    localparam int TABLE_LEN    = 24;

    localparam int ANG_W        = 14;
    localparam int TRIG_W       = 34;
    localparam int CS_W         = 33;
    localparam int FRAC         = 30;

    localparam int SUM_W        = 64;
    localparam int ROOT_W       = 32;
    localparam int SH_W         = 5;
    localparam int NORM_STEPS   = 5;
    localparam int LEN_DEPTH    = 2 + NORM_STEPS + ROOT_W + 1;

    localparam int UNIT_W       = 32;
    localparam int REM_W        = 33;
    localparam int Q_BITS       = 31;
    localparam int DIV_DEPTH    = Q_BITS + 2;

    localparam int PAIR_W       = 33;
    localparam int OC_W         = 34;
    localparam int M_W          = 36;
    localparam int ENTRY_MAX    = 131071;
    localparam int ENTRY_MIN    = -131072;

    localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
    } t_cs;

    typedef struct packed {
        logic       deg;
        logic [2:0] neg;
    } t_len_side;

    typedef logic signed [ENTRY_W-1:0] t_entry;

endpackage

FILE: rtl/aar_in_if.sv
// input channel: angle and axis vector with valid/ready
interface aar_in_if #(parameter int AXIS_WIDTH = 24);
    logic                                valid;
    logic                                ready;
    logic signed [aar_pkg::ANGLE_W-1:0]  angle;
    logic signed [AXIS_WIDTH-1:0]        axis_x;
    logic signed [AXIS_WIDTH-1:0]        axis_y;
    logic signed [AXIS_WIDTH-1:0]        axis_z;

    modport source (output valid, angle, axis_x, axis_y, axis_z, input ready);
    modport sink (input valid, angle, axis_x, axis_y, axis_z, output ready);
endinterface

FILE: rtl/aar_out_if.sv
// output channel: matrix entries and valid flag with valid/ready
interface aar_out_if;
    logic                 valid;
    logic                 ready;
    logic                 matrix_valid;
    aar_pkg::t_entry      r0c0;
    aar_pkg::t_entry      r1c0;
    aar_pkg::t_entry      r2c0;
    aar_pkg::t_entry      r0c1;
    aar_pkg::t_entry      r1c1;
    aar_pkg::t_entry      r2c1;
    aar_pkg::t_entry      r0c2;
    aar_pkg::t_entry      r1c2;
    aar_pkg::t_entry      r2c2;

    modport source (output valid, matrix_valid, r0c0, r1c0, r2c0, r0c1, r1c1, r2c1,
                    r0c2, r1c2, r2c2, input ready);
    modport sink (input valid, matrix_valid, r0c0, r1c0, r2c0, r0c1, r1c1, r2c1,
                  r0c2, r1c2, r2c2, output ready);
endinterface

FILE: rtl/aar_trig.sv
// angle reduction and pipelined cordic for sine and cosine
module aar_trig #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [aar_pkg::ANGLE_W-1:0] i_angle,
    output aar_pkg::t_cs                       o_cs
);
    import aar_pkg::*;

    localparam int STEPS = (TRIG_ITERATIONS < TABLE_LEN) ? TRIG_ITERATIONS : TABLE_LEN;

    logic signed [17:0]       a_ext;
    logic signed [17:0]       n_mod;
    logic signed [17:0]       n_half;
    logic signed [ANG_W-1:0]  n_ang;
    logic                     n_flip;
    logic signed [ANG_W-1:0]  r_ang;
    logic                     r_flip_a;

    logic signed [TRIG_W-1:0] r_x [0:STEPS];
    logic signed [TRIG_W-1:0] r_y [0:STEPS];
    logic signed [TRIG_W-1:0] r_z [0:STEPS];
    logic                     r_flip [0:STEPS];
    logic signed [TRIG_W-1:0] n_x [0:STEPS-1];
    logic signed [TRIG_W-1:0] n_y [0:STEPS-1];
    logic signed [TRIG_W-1:0] n_z [0:STEPS-1];

    // reduce to one quarter turn either side of zero
    always_comb begin
        a_ext = {{2{i_angle[ANGLE_W-1]}}, i_angle};
        if (a_ext < -FULL_TURN) begin
            n_mod = 18'(a_ext + 2 * FULL_TURN);
        end else if (a_ext < 0) begin
            n_mod = 18'(a_ext + FULL_TURN);
        end else if (a_ext >= FULL_TURN) begin
            n_mod = 18'(a_ext - FULL_TURN);
        end else begin
            n_mod = a_ext;
        end
        n_half = (n_mod > HALF_TURN) ? 18'(n_mod - FULL_TURN) : n_mod;
        n_flip = 1'b0;
        n_ang  = ANG_W'(n_half);
        if (n_half > QUARTER_TURN) begin
            n_ang  = ANG_W'(n_half - HALF_TURN);
            n_flip = 1'b1;
        end else if (n_half < -QUARTER_TURN) begin
            n_ang  = ANG_W'(n_half + HALF_TURN);
            n_flip = 1'b1;
        end
    end

    always_comb begin
        for (int i = 0; i < STEPS; i++) begin
            if (r_z[i] >= 0) begin
                n_x[i] = r_x[i] - (r_y[i] >>> i);
                n_y[i] = r_y[i] + (r_x[i] >>> i);
                n_z[i] = r_z[i] - TRIG_W'(ATAN_Q30[i]);
            end else begin
                n_x[i] = r_x[i] + (r_y[i] >>> i);
                n_y[i] = r_y[i] - (r_x[i] >>> i);
                n_z[i] = r_z[i] + TRIG_W'(ATAN_Q30[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang    <= n_ang;
            r_flip_a <= n_flip;
            r_x[0]    <= TRIG_W'(CORDIC_GAIN);
            r_y[0]    <= '0;
            r_z[0]    <= TRIG_W'(r_ang * RAD_PER_UNIT);
            r_flip[0] <= r_flip_a;
            for (int i = 0; i < STEPS; i++) begin
                r_x[i+1]    <= n_x[i];
                r_y[i+1]    <= n_y[i];
                r_z[i+1]    <= n_z[i];
                r_flip[i+1] <= r_flip[i];
            end
            o_cs.c <= r_flip[STEPS] ? CS_W'(-r_x[STEPS]) : CS_W'(r_x[STEPS]);
            o_cs.s <= r_flip[STEPS] ? CS_W'(-r_y[STEPS]) : CS_W'(r_y[STEPS]);
        end
    end

endmodule

FILE: rtl/aar_len.sv
// axis length: squares, normalizing shift and pipelined square root
module aar_len #(
    parameter int AXIS_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [AXIS_WIDTH-1:0]       i_axis [3],
    input  logic [aar_pkg::CFG_W-1:0]   i_min_len,
    output logic                        o_vld,
    output logic [aar_pkg::ROOT_W-1:0]  o_len,
    output logic [aar_pkg::SH_W-1:0]    o_sh,
    output logic [AXIS_WIDTH-1:0]       o_mag [3],
    output aar_pkg::t_len_side          o_side
);
    import aar_pkg::*;

    localparam int W  = AXIS_WIDTH;
    localparam int NS = NORM_STEPS + ROOT_W;
    localparam int LIM_W = CFG_W + 32;

    logic [W-1:0]       n_mag [3];
    logic [2*W-1:0]     r1_sq [3];
    logic [W-1:0]       r1_mag [3];
    logic [2:0]         r1_neg;
    logic               r1_vld;
    logic [SUM_W-1:0]   n_sum;

    logic [SUM_W-1:0]   r_v [0:NS];
    logic [SUM_W-1:0]   r_r [0:NS];
    logic [SH_W-1:0]    r_sh [0:NS];
    logic               r_zero [0:NS];
    logic [W-1:0]       r_mag [0:NS][3];
    logic [2:0]         r_neg [0:NS];
    logic               r_vld [0:NS];
    logic [SUM_W-1:0]   n_v [0:NS-1];
    logic [SUM_W-1:0]   n_r [0:NS-1];
    logic [SH_W-1:0]    n_sh [0:NS-1];
    logic [LIM_W-1:0]   lim;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = i_axis[k][W-1] ? W'(-i_axis[k]) : i_axis[k];
        end
        n_sum = SUM_W'(r1_sq[0]) + SUM_W'(r1_sq[1]) + SUM_W'(r1_sq[2]);
    end

    // first the bit-pair normalization, then one root bit per stage
    always_comb begin
        int               p;
        int               j;
        logic [SUM_W-1:0] b_one;
        logic [SUM_W-1:0] trial;
        for (int s = 0; s < NS; s++) begin
            n_v[s]  = r_v[s];
            n_r[s]  = r_r[s];
            n_sh[s] = r_sh[s];
            if (s < NORM_STEPS) begin
                p = 1 << (NORM_STEPS - 1 - s);
                if ((r_v[s] >> (SUM_W - 2 * p)) == '0) begin
                    n_v[s]  = r_v[s] << (2 * p);
                    n_sh[s] = SH_W'(r_sh[s] + p);
                end
            end else begin
                j     = s - NORM_STEPS;
                b_one = SUM_W'(1) << (SUM_W - 2 - 2 * j);
                trial = r_r[s] + b_one;
                if (r_v[s] >= trial) begin
                    n_v[s] = r_v[s] - trial;
                    n_r[s] = (r_r[s] >> 1) + b_one;
                end else begin
                    n_r[s] = r_r[s] >> 1;
                end
            end
        end
        lim = LIM_W'(i_min_len) << r_sh[NS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_sq[k]  <= n_mag[k] * n_mag[k];
                r1_mag[k] <= n_mag[k];
                r1_neg[k] <= i_axis[k][W-1];
            end
            r_v[0]    <= n_sum;
            r_r[0]    <= '0;
            r_sh[0]   <= '0;
            r_zero[0] <= (n_sum == '0);
            r_mag[0]  <= r1_mag;
            r_neg[0]  <= r1_neg;
            for (int s = 0; s < NS; s++) begin
                r_v[s+1]    <= n_v[s];
                r_r[s+1]    <= n_r[s];
                r_sh[s+1]   <= n_sh[s];
                r_zero[s+1] <= r_zero[s];
                r_mag[s+1]  <= r_mag[s];
                r_neg[s+1]  <= r_neg[s];
            end
            o_len      <= ROOT_W'(r_r[NS]);
            o_sh       <= r_sh[NS];
            o_mag      <= r_mag[NS];
            o_side.neg <= r_neg[NS];
            o_side.deg <= r_zero[NS] || (r_r[NS] == '0) || (r_r[NS] < SUM_W'(lim));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            for (int s = 0; s <= NS; s++) begin
                r_vld[s] <= 1'b0;
            end
            o_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld   <= i_vld;
            r_vld[0] <= r1_vld;
            for (int s = 0; s < NS; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
            o_vld <= r_vld[NS];
        end
    end

endmodule

FILE: rtl/aar_div.sv
// three-lane pipelined restoring divider for the unit axis
module aar_div #(
    parameter int AXIS_WIDTH = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic [aar_pkg::ROOT_W-1:0]        i_len,
    input  logic [aar_pkg::SH_W-1:0]          i_sh,
    input  logic [AXIS_WIDTH-1:0]             i_mag [3],
    input  aar_pkg::t_len_side                i_side,
    output logic                              o_vld,
    output logic                              o_deg,
    output logic signed [aar_pkg::UNIT_W-1:0] o_unit [3]
);
    import aar_pkg::*;

    localparam int SHL_W = AXIS_WIDTH + 31;

    logic [REM_W-1:0]   r_rem [0:Q_BITS][3];
    logic [Q_BITS-1:0]  r_q   [0:Q_BITS][3];
    logic [ROOT_W-1:0]  r_len [0:Q_BITS];
    t_len_side          r_side [0:Q_BITS];
    logic               r_vld [0:Q_BITS];
    logic [REM_W-1:0]   n_rem [0:Q_BITS-1][3];
    logic [Q_BITS-1:0]  n_q   [0:Q_BITS-1][3];
    logic [REM_W-1:0]   n_rem0 [3];

    always_comb begin
        logic [SHL_W-1:0] shl;
        logic [REM_W-1:0] dif;
        logic             ge;
        for (int k = 0; k < 3; k++) begin
            shl       = SHL_W'(i_mag[k]) << i_sh;
            n_rem0[k] = REM_W'(shl);
        end
        for (int t = 0; t < Q_BITS; t++) begin
            for (int k = 0; k < 3; k++) begin
                ge  = r_rem[t][k] >= REM_W'(r_len[t]);
                dif = ge ? (r_rem[t][k] - REM_W'(r_len[t])) : r_rem[t][k];
                n_q[t][k] = r_q[t][k] | (Q_BITS'(ge) << (Q_BITS - 1 - t));
                n_rem[t][k] = (t < Q_BITS - 1) ? (dif << 1) : dif;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_rem[0][k] <= n_rem0[k];
                r_q[0][k]   <= '0;
            end
            r_len[0]  <= i_len;
            r_side[0] <= i_side;
            for (int t = 0; t < Q_BITS; t++) begin
                r_rem[t+1]  <= n_rem[t];
                r_q[t+1]    <= n_q[t];
                r_len[t+1]  <= r_len[t];
                r_side[t+1] <= r_side[t];
            end
            for (int k = 0; k < 3; k++) begin
                o_unit[k] <= r_side[Q_BITS].neg[k] ? -$signed(UNIT_W'(r_q[Q_BITS][k]))
                                                   : $signed(UNIT_W'(r_q[Q_BITS][k]));
            end
            o_deg <= r_side[Q_BITS].deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t <= Q_BITS; t++) begin
                r_vld[t] <= 1'b0;
            end
            o_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int t = 0; t < Q_BITS; t++) begin
                r_vld[t+1] <= r_vld[t];
            end
            o_vld <= r_vld[Q_BITS];
        end
    end

endmodule

FILE: rtl/aar_mat.sv
// matrix entries: pair products, one-minus-cosine products, sums and rounding
module aar_mat (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic                              i_deg,
    input  logic signed [aar_pkg::UNIT_W-1:0] i_unit [3],
    input  aar_pkg::t_cs                      i_cs,
    output logic                              o_vld,
    output logic                              o_flag,
    output aar_pkg::t_entry                   o_entry [9]
);
    import aar_pkg::*;

    function automatic logic signed [PAIR_W-1:0] mul_uu(
        input logic signed [UNIT_W-1:0] a,
        input logic signed [UNIT_W-1:0] b
    );
        logic signed [2*UNIT_W-1:0] p;
        p = a * b;
        return PAIR_W'(p >>> FRAC);
    endfunction

    function automatic logic signed [PAIR_W-1:0] mul_us(
        input logic signed [UNIT_W-1:0] a,
        input logic signed [CS_W-1:0]   b
    );
        logic signed [UNIT_W+CS_W-1:0] p;
        p = a * b;
        return PAIR_W'(p >>> FRAC);
    endfunction

    function automatic logic signed [M_W-1:0] mul_oc(
        input logic signed [PAIR_W-1:0] a,
        input logic signed [OC_W-1:0]   b
    );
        logic signed [PAIR_W+OC_W-1:0] p;
        p = a * b;
        return M_W'(p >>> FRAC);
    endfunction

    function automatic t_entry to_entry(input logic signed [M_W-1:0] v);
        logic signed [M_W-1:0] r;
        r = (v + M_W'(8192)) >>> 14;
        if (r > ENTRY_MAX) begin
            return t_entry'(ENTRY_MAX);
        end else if (r < ENTRY_MIN) begin
            return t_entry'(ENTRY_MIN);
        end
        return t_entry'(r);
    endfunction

    // pair order: xx xy xz yy yz zz
    logic signed [PAIR_W-1:0] r_a_pair [6];
    logic signed [PAIR_W-1:0] r_a_us [3];
    logic signed [CS_W-1:0]   r_a_c;
    logic signed [OC_W-1:0]   r_a_oc;
    logic                     r_a_deg;
    logic                     r_a_vld;

    logic signed [M_W-1:0]    r_b_t [6];
    logic signed [M_W-1:0]    r_b_us [3];
    logic signed [M_W-1:0]    r_b_c;
    logic                     r_b_deg;
    logic                     r_b_vld;

    logic signed [M_W-1:0]    n_m [9];

    always_comb begin
        n_m[0] = r_b_t[0] + r_b_c;
        n_m[1] = r_b_t[1] + r_b_us[2];
        n_m[2] = r_b_t[2] - r_b_us[1];
        n_m[3] = r_b_t[1] - r_b_us[2];
        n_m[4] = r_b_t[3] + r_b_c;
        n_m[5] = r_b_t[4] + r_b_us[0];
        n_m[6] = r_b_t[2] + r_b_us[1];
        n_m[7] = r_b_t[4] - r_b_us[0];
        n_m[8] = r_b_t[5] + r_b_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pair[0] <= mul_uu(i_unit[0], i_unit[0]);
            r_a_pair[1] <= mul_uu(i_unit[0], i_unit[1]);
            r_a_pair[2] <= mul_uu(i_unit[0], i_unit[2]);
            r_a_pair[3] <= mul_uu(i_unit[1], i_unit[1]);
            r_a_pair[4] <= mul_uu(i_unit[1], i_unit[2]);
            r_a_pair[5] <= mul_uu(i_unit[2], i_unit[2]);
            for (int k = 0; k < 3; k++) begin
                r_a_us[k] <= mul_us(i_unit[k], i_cs.s);
            end
            r_a_c   <= i_cs.c;
            r_a_oc  <= OC_W'(1 <<< FRAC) - OC_W'(i_cs.c);
            r_a_deg <= i_deg;

            for (int k = 0; k < 6; k++) begin
                r_b_t[k] <= mul_oc(r_a_pair[k], r_a_oc);
            end
            for (int k = 0; k < 3; k++) begin
                r_b_us[k] <= M_W'(r_a_us[k]);
            end
            r_b_c   <= M_W'(r_a_c);
            r_b_deg <= r_a_deg;

            o_flag <= !r_b_deg;
            for (int k = 0; k < 9; k++) begin
                o_entry[k] <= r_b_deg ? '0 : to_entry(n_m[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            o_vld   <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            o_vld   <= r_b_vld;
        end
    end

endmodule

FILE: rtl/axis_angle_rotation_matrix.sv
// axis-angle rotation matrix top level: pipeline, delay line and register port
// pipeline stages from input transfer to result:
//   40 length and root stages, 33 divider stages, 3 matrix stages
// throughput: one item per cycle; the whole pipeline holds only while the
//   output register is full and not taken
// reset clears all valid bits and sets min_axis_length to 7
module axis_angle_rotation_matrix #(
    parameter int AXIS_WIDTH      = 24,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    aar_in_if.sink                        i_in,
    aar_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aar_pkg::PADDR_W-1:0]   paddr,
    input  logic [aar_pkg::PDATA_W-1:0]   pwdata,
    output logic [aar_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import aar_pkg::*;

    localparam int STEPS = (TRIG_ITERATIONS < TABLE_LEN) ? TRIG_ITERATIONS : TABLE_LEN;
    localparam int DLY   = LEN_DEPTH + DIV_DEPTH - (STEPS + 3);

    logic               en;
    logic [CFG_W-1:0]   r_min_len;
    logic [AXIS_WIDTH-1:0] axis_in [3];

    t_cs                trig_cs;
    t_cs                r_dly [0:DLY-1];

    logic               len_vld;
    logic [ROOT_W-1:0]  len_len;
    logic [SH_W-1:0]    len_sh;
    logic [AXIS_WIDTH-1:0] len_mag [3];
    t_len_side          len_side;

    logic               div_vld;
    logic               div_deg;
    logic signed [UNIT_W-1:0] div_unit [3];

    logic               mat_vld;
    logic               mat_flag;
    t_entry             mat_entry [9];

    assign en         = !mat_vld || o_out.ready;
    assign i_in.ready = en;

    assign axis_in[0] = i_in.axis_x;
    assign axis_in[1] = i_in.axis_y;
    assign axis_in[2] = i_in.axis_z;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= CFG_W'(MIN_AXIS_RESET);
        end else if (psel && penable && pwrite
                     && (paddr[PADDR_W-1:2] == REG_MIN_AXIS_LENGTH)) begin
            r_min_len <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_MIN_AXIS_LENGTH: prdata = PDATA_W'(r_min_len);
            default:             prdata = '0;
        endcase
    end

    aar_trig #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_in.angle),
        .o_cs    (trig_cs)
    );

    // align sine and cosine with the axis path
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= trig_cs;
            for (int k = 1; k < DLY; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    aar_len #(.AXIS_WIDTH(AXIS_WIDTH)) u_len (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (i_in.valid),
        .i_axis    (axis_in),
        .i_min_len (r_min_len),
        .o_vld     (len_vld),
        .o_len     (len_len),
        .o_sh      (len_sh),
        .o_mag     (len_mag),
        .o_side    (len_side)
    );

    aar_div #(.AXIS_WIDTH(AXIS_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (len_vld),
        .i_len   (len_len),
        .i_sh    (len_sh),
        .i_mag   (len_mag),
        .i_side  (len_side),
        .o_vld   (div_vld),
        .o_deg   (div_deg),
        .o_unit  (div_unit)
    );

    aar_mat u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (div_vld),
        .i_deg   (div_deg),
        .i_unit  (div_unit),
        .i_cs    (r_dly[DLY-1]),
        .o_vld   (mat_vld),
        .o_flag  (mat_flag),
        .o_entry (mat_entry)
    );

    assign o_out.valid        = mat_vld;
    assign o_out.matrix_valid = mat_flag;
    assign o_out.r0c0         = mat_entry[0];
    assign o_out.r1c0         = mat_entry[1];
    assign o_out.r2c0         = mat_entry[2];
    assign o_out.r0c1         = mat_entry[3];
    assign o_out.r1c1         = mat_entry[4];
    assign o_out.r2c1         = mat_entry[5];
    assign o_out.r0c2         = mat_entry[6];
    assign o_out.r1c2         = mat_entry[7];
    assign o_out.r2c2         = mat_entry[8];

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the axis-angle rotation matrix block
module testbench;
    import aar_pkg::*;

    localparam int AXIS_W = 24;
    localparam int TRIG_STEPS = 16;
    localparam int LATENCY = 76;

    typedef struct {
        bit     ok;
        t_entry m [9];
    } rot_t;

    typedef struct {
        logic signed [15:0]       ang;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
        bit                       degen;
    } row_t;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    aar_in_if #(.AXIS_WIDTH(AXIS_W)) in_ch();
    aar_out_if out_ch();

    axis_angle_rotation_matrix #(.AXIS_WIDTH(AXIS_W), .TRIG_ITERATIONS(TRIG_STEPS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bit [15:0] min_len;
    rot_t      pending [$];
    bit        typed_q [$];
    rot_t      typed_val [$];
    int        errors = 0;
    int        sent = 0, received = 0, degenerate = 0, cfg_writes = 0;
    bit        calm = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

    function automatic bit [63:0] root_of(bit [63:0] v);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic t_entry to_entry(longint v);
        longint r;
        r = (v + 64'sd8192) >>> 14;
        if (r > ENTRY_MAX) r = ENTRY_MAX;
        if (r < ENTRY_MIN) r = ENTRY_MIN;
        return r[ENTRY_W-1:0];
    endfunction

    function automatic longint unit_of(longint a, int sh, bit [63:0] len);
        bit [63:0] mag;
        longint q;
        mag = (a < 0) ? -a : a;
        q = ((mag << sh) << 30) / len;
        return (a < 0) ? -q : q;
    endfunction

    function automatic rot_t rotation_of(logic signed [15:0] ang,
                                         logic signed [AXIS_W-1:0] axr, ayr, azr);
        rot_t res;
        longint r, z, cx, cy, dx, dy, c, s, oc, x, y, w, ax, ay, az;
        longint m [9];
        bit [63:0] sum, len;
        bit flip;
        int sh;
        flip = 0;
        sh = 0;
        ax = axr; ay = ayr; az = azr;
        r = longint'(ang) % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        if (r > HALF_TURN) r -= FULL_TURN;
        if (r > QUARTER_TURN) begin
            r -= HALF_TURN;
            flip = 1;
        end else if (r < -QUARTER_TURN) begin
            r += HALF_TURN;
            flip = 1;
        end
        z = r * RAD_PER_UNIT;
        cx = CORDIC_GAIN;
        cy = 0;
        for (int i = 0; i < TRIG_STEPS; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (z >= 0) begin
                cx -= dx; cy += dy; z -= longint'({32'b0, ATAN_Q30[i]});
            end else begin
                cx += dx; cy -= dy; z += longint'({32'b0, ATAN_Q30[i]});
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
        sum = ax * ax + ay * ay + az * az;
        while (sh < 31 && (sum >> (62 - 2 * sh)) == 0) sh++;
        len = root_of(sum << (2 * sh));
        res.ok = 0;
        foreach (res.m[k]) res.m[k] = '0;
        if (sum == 0 || len == 0 || len < ({48'b0, min_len} << sh)) return res;
        x = unit_of(ax, sh, len);
        y = unit_of(ay, sh, len);
        w = unit_of(az, sh, len);
        oc = (64'sd1 << 30) - c;
        m[0] = qmul(qmul(x, x), oc) + c;
        m[1] = qmul(qmul(y, x), oc) + qmul(w, s);
        m[2] = qmul(qmul(w, x), oc) - qmul(y, s);
        m[3] = qmul(qmul(x, y), oc) - qmul(w, s);
        m[4] = qmul(qmul(y, y), oc) + c;
        m[5] = qmul(qmul(w, y), oc) + qmul(x, s);
        m[6] = qmul(qmul(x, w), oc) + qmul(y, s);
        m[7] = qmul(qmul(y, w), oc) - qmul(x, s);
        m[8] = qmul(qmul(w, w), oc) + c;
        res.ok = 1;
        foreach (m[k]) res.m[k] = to_entry(m[k]);
        return res;
    endfunction

    // expectation for each input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            pending.insert(pending.size(), rotation_of(in_ch.angle, in_ch.axis_x,
                                                       in_ch.axis_y, in_ch.axis_z));
            sent++;
        end
    end

    // check each output transfer
    always @(posedge i_clk) begin
        rot_t want, got;
        bit typed;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.ok = out_ch.matrix_valid;
            got.m = '{out_ch.r0c0, out_ch.r1c0, out_ch.r2c0, out_ch.r0c1, out_ch.r1c1,
                      out_ch.r2c1, out_ch.r0c2, out_ch.r1c2, out_ch.r2c2};
            received++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result transfer", $time);
                errors++;
            end else begin
                want = pending.pop_front();
                typed = typed_q.pop_front();
                if (typed) want = typed_val.pop_front();
                if (!got.ok) degenerate++;
                if (got.ok !== want.ok) begin
                    $display("%0t: matrix_valid expected %0d got %0d", $time, want.ok, got.ok);
                    errors++;
                end
                foreach (want.m[k])
                    if (got.m[k] !== want.m[k]) begin
                        $display("%0t: entry %0d expected %0d got %0d", $time, k,
                                 want.m[k], got.m[k]);
                        errors++;
                    end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 0;
        else out_ch.ready <= calm || ($urandom_range(99) >= 14);
    end

    task automatic send(logic signed [15:0] ang, logic signed [AXIS_W-1:0] ax, ay, az,
                        bit degen);
        rot_t zero;
        while (!calm && $urandom_range(99) < 14) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        zero.ok = 0;
        foreach (zero.m[k]) zero.m[k] = '0;
        typed_q.insert(typed_q.size(), degen);
        if (degen) typed_val.insert(typed_val.size(), zero);
        in_ch.valid <= 1;
        in_ch.angle <= ang;
        in_ch.axis_x <= ax;
        in_ch.axis_y <= ay;
        in_ch.axis_z <= az;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic drain_and_write(bit [15:0] value);
        in_ch.valid <= 0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= PADDR_W'(REG_MIN_AXIS_LENGTH * 4);
        pwdata <= {16'b0, value};
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        min_len = value;
        cfg_writes++;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge i_clk);
    endtask

    function automatic logic signed [AXIS_W-1:0] rand_axis();
        int pick;
        logic signed [AXIS_W-1:0] v;
        pick = $urandom_range(9);
        v = AXIS_W'($urandom);
        if (pick < 4) return v;
        if (pick < 8) return v >>> $urandom_range(22);
        return AXIS_W'(int'($urandom_range(20)) - 10);
    endfunction

    row_t rows [$];
    initial begin
        bit [15:0] phase_len [4];
        in_ch.valid = 0;
        in_ch.angle = 0;
        in_ch.axis_x = 0;
        in_ch.axis_y = 0;
        in_ch.axis_z = 0;
        out_ch.ready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        min_len = MIN_AXIS_RESET;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        rows = '{
            '{16'sd0, 24'sd0, 24'sd0, 24'sd0, 1},
            '{16'sd5760, 24'sd1, 24'sd0, 24'sd0, 1},
            '{16'sd100, 24'sd0, -24'sd2, 24'sd3, 1},
            '{16'sd0, 24'sd65536, 24'sd0, 24'sd0, 0},
            '{16'sd5760, 24'sd0, 24'sd65536, 24'sd0, 0},
            '{-16'sd5760, 24'sd0, 24'sd0, 24'sd65536, 0},
            '{16'sd5761, 24'sd65536, 24'sd65536, 24'sd0, 0},
            '{-16'sd5761, 24'sd0, 24'sd65536, 24'sd65536, 0},
            '{16'sd11520, 24'sd65536, 24'sd65536, 24'sd65536, 0},
            '{-16'sd11520, -24'sd65536, 24'sd65536, 24'sd65536, 0},
            '{16'sd23040, 24'sd8388607, 24'sd8388607, 24'sd8388607, 0},
            '{-16'sd23040, -24'sd8388608, -24'sd8388608, -24'sd8388608, 0},
            '{16'sd11519, 24'sd8388607, -24'sd8388608, 24'sd0, 0},
            '{-16'sd11521, -24'sd8388608, 24'sd0, 24'sd8388607, 0},
            '{16'sd17280, 24'sd3, 24'sd4, 24'sd5, 0},
            '{-16'sd17281, 24'sd7, 24'sd0, 24'sd0, 0},
            '{16'sd2880, 24'sd6, 24'sd0, 24'sd0, 1},
            '{16'sd1, -24'sd1, -24'sd1, -24'sd1, 1},
            '{-16'sd1, 24'sd4, 24'sd4, 24'sd4, 0},
            '{16'sd12345, 24'sd4660, -24'sd22136, 24'sd39612, 0}
        };
        foreach (rows[i]) send(rows[i].ang, rows[i].ax, rows[i].ay, rows[i].az, rows[i].degen);

        phase_len = '{16'd0, 16'd65535, 16'($urandom_range(65535)), 16'd7};
        for (int p = 0; p < 4; p++) begin
            drain_and_write(phase_len[p]);
            for (int n = 0; n < 480; n++) begin
                logic signed [15:0] a;
                calm = (p == 1 && n >= 100 && n < 300);
                a = 16'(int'($urandom_range(46080)) - 23040);
                if ($urandom_range(9) == 0) a = 16'(int'($urandom_range(2)) * 5760 - 5760);
                send(a, rand_axis(), rand_axis(), rand_axis(), 0);
            end
        end
        calm = 0;
        in_ch.valid <= 0;
        while (pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        $display("%0d rotation transfers checked, %0d degenerate axes, %0d threshold writes",
                 received, degenerate, cfg_writes);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/aar_pkg.sv
rtl/aar_in_if.sv
rtl/aar_out_if.sv
rtl/aar_trig.sv
rtl/aar_len.sv
rtl/aar_div.sv
rtl/aar_mat.sv
rtl/axis_angle_rotation_matrix.sv
tb/testbench.sv
